// ----- design/lodg_pkg.sv -----
// Shared types, codes, constants and helpers of the log-odds occupancy grid.
package lodg_pkg;

   // Default grid extent (cells per row, rows).
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   // Entries in the command queue between front and back (power of two).
   localparam int QUEUE_DEPTH = 4;

   // Field widths
   localparam int SIZE_W     = 9;
   localparam int INC_W      = 14;
   localparam int VAL_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Operation codes on req_op
   localparam logic [1:0] OP_OCCUPIED = 2'd0;
   localparam logic [1:0] OP_FREE     = 2'd1;
   localparam logic [1:0] OP_QUERY    = 2'd2;

   // Cell class codes on rsp_cell_class
   localparam logic [1:0] CLASS_FREE     = 2'd0;
   localparam logic [1:0] CLASS_OCCUPIED = 2'd1;
   localparam logic [1:0] CLASS_UNKNOWN  = 2'd2;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OCC_INC    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_INC   = 2'd3;

   // Register reset values
   localparam logic [SIZE_W-1:0]        MAP_WIDTH_RESET  = 9'd256;
   localparam logic [SIZE_W-1:0]        MAP_HEIGHT_RESET = 9'd256;
   localparam logic signed [INC_W-1:0]  OCC_INC_RESET    = 14'sd562;
   localparam logic signed [INC_W-1:0]  FREE_INC_RESET   = -14'sd104;

   // Occupied hits only accumulate while the cell is below 50.0 in Q8.8.
   localparam logic signed [VAL_W-1:0] OCC_LIMIT = 16'sd12800;

   // What the back end does to the cell
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_OCC,
      KIND_FREE
   } kind_type;

   // Classified command travelling through the queue (address rides beside it)
   typedef struct packed {
      logic     in_map;
      kind_type kind;
   } cmd_type;

   // Configuration register file
   typedef struct packed {
      logic [SIZE_W-1:0]       map_width;
      logic [SIZE_W-1:0]       map_height;
      logic signed [INC_W-1:0] occ_inc;
      logic signed [INC_W-1:0] free_inc;
   } cfg_type;

   // Queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Saturating add of a 14-bit increment onto a 16-bit cell value
   function automatic logic signed [VAL_W-1:0] sat_add(
      input logic signed [VAL_W-1:0] a,
      input logic signed [INC_W-1:0] b
   );
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {{(VAL_W+1-INC_W){b[INC_W-1]}}, b};
      if (s[VAL_W] != s[VAL_W-1]) begin
         return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      end
      return s[VAL_W-1:0];
   endfunction

   // Class of a cell value: negative free, positive occupied, zero unknown
   function automatic logic [1:0] cell_class_of(input logic signed [VAL_W-1:0] v);
      logic [1:0] c;
      if (v > 0) begin
         c = CLASS_OCCUPIED;
      end else if (v < 0) begin
         c = CLASS_FREE;
      end else begin
         c = CLASS_UNKNOWN;
      end
      return c;
   endfunction

endpackage

// ----- design/lodg_front.sv -----
// Front end: takes request transfers, bounds-checks them and queues a command.
module lodg_front #(
   parameter int MAX_WIDTH  = lodg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lodg_pkg::MAX_HEIGHT_DEF,
   parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_op,
   input  logic [7:0]                req_cell_x,
   input  logic [7:0]                req_cell_y,
   input  lodg_pkg::cfg_type         cfg,
   input  lodg_pkg::queue_status_type q_status,
   input  logic                      clear_busy,
   output logic                      push,
   output lodg_pkg::cmd_type         push_cmd,
   output logic [ADDR_W-1:0]         push_addr
);

   logic in_x;
   logic in_y;

   // Hold off while the grid is being cleared or the queue has no room
   assign req_stall = clear_busy | q_status.full;
   assign push      = req_valid & ~req_stall;

   // Effective size is the smaller of the register and the grid extent
   assign in_x = (int'(req_cell_x) < int'(cfg.map_width)) && (int'(req_cell_x) < MAX_WIDTH);
   assign in_y = (int'(req_cell_y) < int'(cfg.map_height)) && (int'(req_cell_y) < MAX_HEIGHT);

   // Classify the operation; out-of-map cells are never touched
   always_comb begin
      push_cmd.in_map = in_x & in_y;
      case (req_op)
         lodg_pkg::OP_OCCUPIED: push_cmd.kind = lodg_pkg::KIND_OCC;
         lodg_pkg::OP_FREE:     push_cmd.kind = lodg_pkg::KIND_FREE;
         default:               push_cmd.kind = lodg_pkg::KIND_NONE;
      endcase
      if (!(in_x & in_y)) begin
         push_cmd.kind = lodg_pkg::KIND_NONE;
      end
   end

   // Row-major cell address
   assign push_addr = ADDR_W'(int'(req_cell_y) * MAX_WIDTH + int'(req_cell_x));

endmodule

// ----- design/lodg_queue.sv -----
// Short command queue decoupling the front end from the back end.
module lodg_queue #(
   parameter int DATA_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          pop_data,
   output lodg_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(lodg_pkg::QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [DATA_W-1:0] entry_ff [lodg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign status.full  = (count_ff == CNT_W'(lodg_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // Fill count follows push and pop
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/lodg_back.sv -----
// Back end: clears the memory after reset; per command reads the cell, writes back updates.
module lodg_back #(
   parameter int MAX_WIDTH  = lodg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lodg_pkg::MAX_HEIGHT_DEF,
   parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lodg_pkg::cfg_type                 cfg,
   input  lodg_pkg::queue_status_type        q_status,
   input  lodg_pkg::cmd_type                 head_cmd,
   input  logic [ADDR_W-1:0]                 head_addr,
   output logic                              pop,
   output logic                              clear_busy,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_in_map,
   output logic [1:0]                        rsp_cell_class,
   output logic signed [lodg_pkg::VAL_W-1:0] rsp_log_odds
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_FETCH,
      ST_UPDATE
   } state_type;

   state_type                         state_ff;
   logic [ADDR_W-1:0]                 clr_cnt_ff;
   lodg_pkg::cmd_type                 cmd_ff;
   logic [ADDR_W-1:0]                 addr_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_in_map_ff;
   logic [1:0]                        rsp_cell_class_ff;
   logic signed [lodg_pkg::VAL_W-1:0] rsp_log_odds_ff;

   logic signed [lodg_pkg::VAL_W-1:0] mem [DEPTH];
   logic signed [lodg_pkg::VAL_W-1:0] rd_data_ff;

   logic                              commit;
   logic                              mem_we;
   logic [ADDR_W-1:0]                 mem_addr;
   logic signed [lodg_pkg::VAL_W-1:0] mem_wdata;
   logic signed [lodg_pkg::VAL_W-1:0] upd_val;
   logic signed [lodg_pkg::VAL_W-1:0] result_val;

   assign clear_busy = (state_ff == ST_CLEAR);
   assign pop        = (state_ff == ST_FETCH) & ~q_status.empty;
   // Result leaves when the output register is empty or being taken
   assign commit     = (state_ff == ST_UPDATE) & (~rsp_valid_ff | ~rsp_stall);

   // Cell update
   always_comb begin
      case (cmd_ff.kind)
         lodg_pkg::KIND_OCC: begin
            upd_val = (rd_data_ff < lodg_pkg::OCC_LIMIT) ?
                      lodg_pkg::sat_add(rd_data_ff, cfg.occ_inc) : rd_data_ff;
         end
         lodg_pkg::KIND_FREE: upd_val = lodg_pkg::sat_add(rd_data_ff, cfg.free_inc);
         default:             upd_val = rd_data_ff;
      endcase
      result_val = cmd_ff.in_map ? upd_val : '0;
   end

   // Single memory port: clear sweep, fetch read, or write-back
   always_comb begin
      case (state_ff)
         ST_CLEAR: mem_addr = clr_cnt_ff;
         ST_FETCH: mem_addr = head_addr;
         default:  mem_addr = addr_ff;
      endcase
      mem_we    = clear_busy | (commit & (cmd_ff.kind != lodg_pkg::KIND_NONE));
      mem_wdata = clear_busy ? '0 : upd_val;
   end

   // Cell memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
                  state_ff <= ST_FETCH;
               end
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
            ST_FETCH: begin
               if (pop) begin
                  cmd_ff   <= head_cmd;
                  addr_ff  <= head_addr;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (commit) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_in_map_ff     <= cmd_ff.in_map;
                  rsp_log_odds_ff   <= result_val;
                  rsp_cell_class_ff <= lodg_pkg::cell_class_of(result_val);
                  state_ff          <= ST_FETCH;
               end
            end
            default: state_ff <= ST_FETCH;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_in_map     = rsp_in_map_ff;
   assign rsp_cell_class = rsp_cell_class_ff;
   assign rsp_log_odds   = rsp_log_odds_ff;

endmodule

// ----- design/log_odds_occupancy_grid.sv -----
// Log-odds occupancy grid: a MAX_WIDTH x MAX_HEIGHT grid of signed Q8.8 cells held
// in one single-port memory. Each request transfer marks a cell occupied, marks it
// free or queries it, and yields one response with the in-map flag, the class and
// the cell value after the update. The single memory port reads the cell in the
// fetch state and writes it back in the update state, so the back end works on one
// command at a time while further requests wait in the command queue. After reset the
// memory is swept to zero, one cell a cycle, across all MAX_WIDTH*MAX_HEIGHT cells (65536
// at the default size); req_stall stays high during that sweep, while csr writes are
// taken at any time (csr_ready is always high). Registers should only be written
// while no request is in flight.
module log_odds_occupancy_grid #(
   parameter int MAX_WIDTH  = lodg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lodg_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_op,
   input  logic [7:0]                           req_cell_x,
   input  logic [7:0]                           req_cell_y,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_in_map,
   output logic [1:0]                           rsp_cell_class,
   output logic signed [lodg_pkg::VAL_W-1:0]    rsp_log_odds,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lodg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lodg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int CMD_W  = $bits(lodg_pkg::cmd_type);
   localparam int DATA_W = CMD_W + ADDR_W;

   lodg_pkg::cfg_type          cfg_ff;
   lodg_pkg::queue_status_type q_status;
   lodg_pkg::cmd_type          push_cmd;
   lodg_pkg::cmd_type          head_cmd;
   logic [ADDR_W-1:0]          push_addr;
   logic [ADDR_W-1:0]          head_addr;
   logic [DATA_W-1:0]          push_data;
   logic [DATA_W-1:0]          pop_data;
   logic                       push;
   logic                       pop;
   logic                       clear_busy;

   assign csr_ready = 1'b1;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_width  <= lodg_pkg::MAP_WIDTH_RESET;
         cfg_ff.map_height <= lodg_pkg::MAP_HEIGHT_RESET;
         cfg_ff.occ_inc    <= lodg_pkg::OCC_INC_RESET;
         cfg_ff.free_inc   <= lodg_pkg::FREE_INC_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lodg_pkg::CSR_MAP_WIDTH:  cfg_ff.map_width  <= csr_wdata[lodg_pkg::SIZE_W-1:0];
            lodg_pkg::CSR_MAP_HEIGHT: cfg_ff.map_height <= csr_wdata[lodg_pkg::SIZE_W-1:0];
            lodg_pkg::CSR_OCC_INC:    cfg_ff.occ_inc    <= csr_wdata[lodg_pkg::INC_W-1:0];
            lodg_pkg::CSR_FREE_INC:   cfg_ff.free_inc   <= csr_wdata[lodg_pkg::INC_W-1:0];
            default: ;
         endcase
      end
   end

   lodg_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_op     (req_op),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .clear_busy (clear_busy),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_addr  (push_addr)
   );

   // Queue entry: command over address
   assign push_data = {push_cmd, push_addr};
   assign head_cmd  = lodg_pkg::cmd_type'(pop_data[DATA_W-1 -: CMD_W]);
   assign head_addr = pop_data[ADDR_W-1:0];

   lodg_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   lodg_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_status       (q_status),
      .head_cmd       (head_cmd),
      .head_addr      (head_addr),
      .pop            (pop),
      .clear_busy     (clear_busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_in_map     (rsp_in_map),
      .rsp_cell_class (rsp_cell_class),
      .rsp_log_odds   (rsp_log_odds)
   );

`ifndef ASSERT_OFF
   // No response can come out while the memory sweep is running
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !rsp_valid)
      else $error("response during memory clear");

   // No request transfer is taken during the sweep
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !clear_busy)
      else $error("request taken during memory clear");

   // Out-of-map responses carry a zero, unknown cell
   a_out_of_map_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_map) |->
         (rsp_log_odds == '0) && (rsp_cell_class == lodg_pkg::CLASS_UNKNOWN))
      else $error("out-of-map response carries a value");

   // Class agrees with the sign of the value
   a_class_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_cell_class == lodg_pkg::CLASS_OCCUPIED) == (rsp_log_odds > 0)) &&
         ((rsp_cell_class == lodg_pkg::CLASS_FREE) == (rsp_log_odds < 0)))
      else $error("cell class does not match log-odds sign");
`endif

endmodule

// ----- test/log_odds_occupancy_grid_tb.sv -----
// Self-checking testbench for the log-odds occupancy grid: directed plan, then random phases.
module log_odds_occupancy_grid_tb;

   localparam int GRID_CELLS    = lodg_pkg::MAX_WIDTH_DEF * lodg_pkg::MAX_HEIGHT_DEF;
   // Longest quiet stretch of a correct run is the clearing sweep after reset.
   localparam int IDLE_LIMIT    = 4 * GRID_CELLS;
   // Cycles left after the last response before a register write or the end.
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_ITEMS  = 1100;
   // Op code with no function of its own; the block treats it as a query.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                             in_map;
      logic [1:0]                       cell_class;
      logic signed [lodg_pkg::VAL_W-1:0] log_odds;
   } cell_rsp_type;

   // One line of the directed plan: a register write or a request
   typedef struct {
      bit                              is_csr;
      logic [lodg_pkg::CSR_IDX_W-1:0]  csr_idx;
      logic [lodg_pkg::CSR_DATA_W-1:0] csr_data;
      logic [1:0]                      op;
      logic [7:0]                      x;
      logic [7:0]                      y;
      bit                              has_exp;
      cell_rsp_type                    exp_rsp;
   } plan_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BURSTY
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [1:0]                            req_op = lodg_pkg::OP_QUERY;
   logic [7:0]                            req_cell_x = '0;
   logic [7:0]                            req_cell_y = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic                                  rsp_in_map;
   logic [1:0]                            rsp_cell_class;
   logic signed [lodg_pkg::VAL_W-1:0]     rsp_log_odds;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [lodg_pkg::CSR_IDX_W-1:0]        csr_index = '0;
   logic [lodg_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;

   // Grid model and its register copy
   logic signed [lodg_pkg::VAL_W-1:0] grid_model [0:GRID_CELLS-1];
   logic [lodg_pkg::SIZE_W-1:0]       cfg_width;
   logic [lodg_pkg::SIZE_W-1:0]       cfg_height;
   logic signed [lodg_pkg::INC_W-1:0] cfg_occ_inc;
   logic signed [lodg_pkg::INC_W-1:0] cfg_free_inc;

   cell_rsp_type   pending_cells [$];
   plan_row_type   directed_plan [$];

   int          burst_left = 0;
   int          fail_count = 0;
   int          idle_run = 0;
   int          n_req = 0;
   int          n_out_of_map = 0;
   int          n_rsp = 0;
   int          n_saturated = 0;
   int          n_csr = 0;
   int          n_settings = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int             stall_tick = 0;
   cell_rsp_type   want;

   log_odds_occupancy_grid #(
      .MAX_WIDTH (lodg_pkg::MAX_WIDTH_DEF),
      .MAX_HEIGHT(lodg_pkg::MAX_HEIGHT_DEF)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_in_map    (rsp_in_map),
      .rsp_cell_class(rsp_cell_class),
      .rsp_log_odds  (rsp_log_odds),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // Saturating add of an increment to a cell value
   function automatic logic signed [lodg_pkg::VAL_W-1:0] clamp_sum(
      input logic signed [lodg_pkg::VAL_W-1:0] v,
      input logic signed [lodg_pkg::INC_W-1:0] inc
   );
      int s;
      s = int'(v) + int'(inc);
      if (s > 32767) begin
         s = 32767;
      end else if (s < -32768) begin
         s = -32768;
      end
      return 16'(s);
   endfunction

   // Apply one request to the grid model and return the response it should give
   function automatic cell_rsp_type update_cell_model(
      input logic [1:0] op,
      input logic [7:0] x,
      input logic [7:0] y
   );
      cell_rsp_type                      r;
      int                                w;
      int                                h;
      int                                idx;
      logic signed [lodg_pkg::VAL_W-1:0] v;
      w = (cfg_width > lodg_pkg::SIZE_W'(lodg_pkg::MAX_WIDTH_DEF)) ?
          lodg_pkg::MAX_WIDTH_DEF : int'(cfg_width);
      h = (cfg_height > lodg_pkg::SIZE_W'(lodg_pkg::MAX_HEIGHT_DEF)) ?
          lodg_pkg::MAX_HEIGHT_DEF : int'(cfg_height);
      v = '0;
      r.in_map = 1'b0;
      if (int'(x) < w && int'(y) < h) begin
         idx = int'(y) * lodg_pkg::MAX_WIDTH_DEF + int'(x);
         v = grid_model[idx];
         if (op == lodg_pkg::OP_OCCUPIED) begin
            if (v < lodg_pkg::OCC_LIMIT) begin
               v = clamp_sum(v, cfg_occ_inc);
            end
         end else if (op == lodg_pkg::OP_FREE) begin
            v = clamp_sum(v, cfg_free_inc);
         end
         grid_model[idx] = v;
         r.in_map = 1'b1;
      end
      if (v > 0) begin
         r.cell_class = lodg_pkg::CLASS_OCCUPIED;
      end else if (v < 0) begin
         r.cell_class = lodg_pkg::CLASS_FREE;
      end else begin
         r.cell_class = lodg_pkg::CLASS_UNKNOWN;
      end
      r.log_odds = v;
      return r;
   endfunction

   function automatic void plan_item(
      input logic [1:0]                        op,
      input logic [7:0]                        x,
      input logic [7:0]                        y,
      input bit                                has_exp = 1'b0,
      input logic                              in_map = 1'b0,
      input logic [1:0]                        cls = lodg_pkg::CLASS_UNKNOWN,
      input logic signed [lodg_pkg::VAL_W-1:0] val = '0
   );
      plan_row_type row;
      row.is_csr = 1'b0;
      row.csr_idx = '0;
      row.csr_data = '0;
      row.op = op;
      row.x = x;
      row.y = y;
      row.has_exp = has_exp;
      row.exp_rsp.in_map = in_map;
      row.exp_rsp.cell_class = cls;
      row.exp_rsp.log_odds = val;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_csr(
      input logic [lodg_pkg::CSR_IDX_W-1:0]  idx,
      input logic [lodg_pkg::CSR_DATA_W-1:0] data
   );
      plan_row_type row;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_data = data;
      row.op = lodg_pkg::OP_QUERY;
      row.x = '0;
      row.y = '0;
      row.has_exp = 1'b0;
      row.exp_rsp = '0;
      directed_plan.push_back(row);
   endfunction

   // Grid sizes: half tiny so hits pile up, the rest zero, full, oversize or any in-grid size
   function automatic logic [lodg_pkg::SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return lodg_pkg::SIZE_W'(lodg_pkg::MAX_WIDTH_DEF);
      end else if (r == 2) begin
         return lodg_pkg::SIZE_W'($urandom_range(257, 511));
      end else if (r <= 12) begin
         return lodg_pkg::SIZE_W'($urandom_range(1, 8));
      end
      return lodg_pkg::SIZE_W'($urandom_range(1, 256));
   endfunction

   // Increments: stated extremes, zero, raw 14-bit codes and ordinary values
   function automatic logic [lodg_pkg::INC_W-1:0] pick_inc();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) begin
         return 14'(4096);
      end else if (r == 1) begin
         return 14'(-4096);
      end else if (r == 2) begin
         return '0;
      end else if (r == 3) begin
         return 14'($urandom);
      end else if (r <= 9) begin
         return 14'(int'($urandom_range(0, 8192)) - 4096);
      end
      return 14'(int'($urandom_range(0, 1200)) - 600);
   endfunction

   // Wait until every response is back and the pipeline has gone quiet
   task automatic drain_grid();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_cells.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(
      input logic [lodg_pkg::CSR_IDX_W-1:0]  idx,
      input logic [lodg_pkg::CSR_DATA_W-1:0] data
   );
      drain_grid();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      case (idx)
         lodg_pkg::CSR_MAP_WIDTH:  cfg_width = data[lodg_pkg::SIZE_W-1:0];
         lodg_pkg::CSR_MAP_HEIGHT: cfg_height = data[lodg_pkg::SIZE_W-1:0];
         lodg_pkg::CSR_OCC_INC:    cfg_occ_inc = data[lodg_pkg::INC_W-1:0];
         lodg_pkg::CSR_FREE_INC:   cfg_free_inc = data[lodg_pkg::INC_W-1:0];
         default: ;
      endcase
      n_csr++;
   endtask

   // Send one request in bursts with random gaps; predict it once transferred
   task automatic send_req(input plan_row_type row);
      int           gap;
      cell_rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= row.op;
      req_cell_x <= row.x;
      req_cell_y <= row.y;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = update_cell_model(row.op, row.x, row.y);
      pending_cells.push_back(row.has_exp ? row.exp_rsp : predicted);
      n_req++;
      if (!predicted.in_map) begin
         n_out_of_map++;
      end
   endtask

   // Response check, then the receiver's stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (pending_cells.size() == 0) begin
            $error("response transfer with nothing expected: in_map %0d class %0d log_odds %0d",
                   rsp_in_map, rsp_cell_class, rsp_log_odds);
            fail_count++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_in_map !== want.in_map) begin
               $error("in_map: expected %0d, got %0d", want.in_map, rsp_in_map);
               fail_count++;
            end
            if (rsp_cell_class !== want.cell_class) begin
               $error("cell_class: expected %0d, got %0d", want.cell_class, rsp_cell_class);
               fail_count++;
            end
            if (rsp_log_odds !== want.log_odds) begin
               $error("log_odds: expected %0d, got %0d", want.log_odds, rsp_log_odds);
               fail_count++;
            end
            if (want.log_odds == 16'sh7FFF || want.log_odds == 16'sh8000) begin
               n_saturated++;
            end
         end
      end
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= ((stall_tick % 12) < 8);
      endcase
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_run <= 0;
      end else if (idle_run >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_run);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      plan_row_type row;
      int           n_random;
      int           n_phase;
      int           w;
      int           h;

      for (int i = 0; i < GRID_CELLS; i++) begin
         grid_model[i] = '0;
      end
      cfg_width = lodg_pkg::MAP_WIDTH_RESET;
      cfg_height = lodg_pkg::MAP_HEIGHT_RESET;
      cfg_occ_inc = lodg_pkg::OCC_INC_RESET;
      cfg_free_inc = lodg_pkg::FREE_INC_RESET;

      // Reset values, corners and the unused op code
      plan_item(lodg_pkg::OP_QUERY, 8'd0, 8'd0, 1'b1, 1'b1,
                lodg_pkg::CLASS_UNKNOWN, 16'sd0);
      plan_item(lodg_pkg::OP_OCCUPIED, 8'd0, 8'd0, 1'b1, 1'b1,
                lodg_pkg::CLASS_OCCUPIED, 16'sd562);
      plan_item(lodg_pkg::OP_FREE, 8'd1, 8'd0, 1'b1, 1'b1,
                lodg_pkg::CLASS_FREE, -16'sd104);
      plan_item(lodg_pkg::OP_QUERY, 8'd255, 8'd255, 1'b1, 1'b1,
                lodg_pkg::CLASS_UNKNOWN, 16'sd0);
      plan_item(OP_UNUSED, 8'd0, 8'd0, 1'b1, 1'b1, lodg_pkg::CLASS_OCCUPIED, 16'sd562);
      plan_item(lodg_pkg::OP_FREE, 8'd0, 8'd0);
      // One-cell map: neighbors are out of map; upper data bits are ignored
      plan_csr(lodg_pkg::CSR_MAP_WIDTH, 16'hFE01);
      plan_csr(lodg_pkg::CSR_MAP_HEIGHT, 16'h0001);
      plan_item(lodg_pkg::OP_OCCUPIED, 8'd1, 8'd0, 1'b1, 1'b0,
                lodg_pkg::CLASS_UNKNOWN, 16'sd0);
      plan_item(lodg_pkg::OP_FREE, 8'd0, 8'd1, 1'b1, 1'b0,
                lodg_pkg::CLASS_UNKNOWN, 16'sd0);
      plan_item(lodg_pkg::OP_OCCUPIED, 8'd0, 8'd0);
      // Zero width puts every cell out of map
      plan_csr(lodg_pkg::CSR_MAP_WIDTH, 16'h0000);
      plan_item(lodg_pkg::OP_QUERY, 8'd0, 8'd0, 1'b1, 1'b0,
                lodg_pkg::CLASS_UNKNOWN, 16'sd0);
      // Oversize width and height clip to the grid
      plan_csr(lodg_pkg::CSR_MAP_WIDTH, 16'h01FF);
      plan_csr(lodg_pkg::CSR_MAP_HEIGHT, 16'h012C);
      plan_item(lodg_pkg::OP_QUERY, 8'd255, 8'd255, 1'b1, 1'b1,
                lodg_pkg::CLASS_UNKNOWN, 16'sd0);
      // Increments beyond the stated range: +8191 occupied, -8192 free
      plan_csr(lodg_pkg::CSR_OCC_INC, 16'h1FFF);
      plan_csr(lodg_pkg::CSR_FREE_INC, 16'hE000);
      plan_item(lodg_pkg::OP_OCCUPIED, 8'd10, 8'd10, 1'b1, 1'b1,
                lodg_pkg::CLASS_OCCUPIED, 16'sd8191);
      // second hit crosses 50.0, third is held since the cell is over the occupied limit
      plan_item(lodg_pkg::OP_OCCUPIED, 8'd10, 8'd10);
      plan_item(lodg_pkg::OP_OCCUPIED, 8'd10, 8'd10);
      plan_item(lodg_pkg::OP_FREE, 8'd10, 8'd10);
      // Negative saturation
      repeat (5) plan_item(lodg_pkg::OP_FREE, 8'd20, 8'd20);
      // Positive saturation through the free increment
      plan_csr(lodg_pkg::CSR_FREE_INC, 16'h5FFF);
      repeat (5) plan_item(lodg_pkg::OP_FREE, 8'd30, 8'd30);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_csr) begin
            write_reg(directed_plan[i].csr_idx, directed_plan[i].csr_data);
         end else begin
            send_req(directed_plan[i]);
         end
      end
      n_settings = 1;

      // Random phases, each under a fresh register setting
      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         write_reg(lodg_pkg::CSR_MAP_WIDTH, {7'($urandom), pick_size()});
         write_reg(lodg_pkg::CSR_MAP_HEIGHT, {7'($urandom), pick_size()});
         write_reg(lodg_pkg::CSR_OCC_INC, {2'($urandom), pick_inc()});
         write_reg(lodg_pkg::CSR_FREE_INC, {2'($urandom), pick_inc()});
         n_settings++;
         w = (cfg_width > lodg_pkg::SIZE_W'(lodg_pkg::MAX_WIDTH_DEF)) ?
             lodg_pkg::MAX_WIDTH_DEF : int'(cfg_width);
         h = (cfg_height > lodg_pkg::SIZE_W'(lodg_pkg::MAX_HEIGHT_DEF)) ?
             lodg_pkg::MAX_HEIGHT_DEF : int'(cfg_height);
         n_phase = (w == 0 || h == 0) ? 20 : $urandom_range(60, 160);
         for (int k = 0; k < n_phase; k++) begin
            row.is_csr = 1'b0;
            row.csr_idx = '0;
            row.csr_data = '0;
            row.has_exp = 1'b0;
            row.exp_rsp = '0;
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8: row.op = lodg_pkg::OP_OCCUPIED;
               9, 10, 11, 12, 13, 14, 15, 16: row.op = lodg_pkg::OP_FREE;
               17, 18: row.op = lodg_pkg::OP_QUERY;
               default: row.op = OP_UNUSED;
            endcase
            // mostly inside the map, the rest anywhere
            row.x = (w > 0 && $urandom_range(0, 9) < 8) ? 8'($urandom_range(0, w - 1))
                                                        : 8'($urandom_range(0, 255));
            row.y = (h > 0 && $urandom_range(0, 9) < 8) ? 8'($urandom_range(0, h - 1))
                                                        : 8'($urandom_range(0, 255));
            send_req(row);
            n_random++;
         end
      end

      drain_grid();
      if (pending_cells.size() != 0) begin
         $error("%0d responses never arrived", pending_cells.size());
         fail_count++;
      end
      $display("Sent %0d requests (%0d outside the map) under %0d register settings, %0d writes.",
               n_req, n_out_of_map, n_settings, n_csr);
      $display("Checked %0d responses, %0d of them at a saturation limit; %0d mismatches.",
               n_rsp, n_saturated, fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
